/* rtl/neighbor_table_with_expiry_unit_defines.svh */
// ----------------------------------------------------------------------------
// Neighbor table assertion macros
// Shared assertion wrappers for the neighbor table RTL.
// ----------------------------------------------------------------------------
`ifndef NEIGHBOR_TABLE_WITH_EXPIRY_UNIT_DEFINES_SVH
`define NEIGHBOR_TABLE_WITH_EXPIRY_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define NTE_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define NTE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);
`else
`define NTE_ASSERT(label, clk, rst_n, prop, msg)
`define NTE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

/* rtl/nte_pkg.sv */
// ----------------------------------------------------------------------------
// Neighbor table package
// Types, constants and codes shared by the neighbor table modules.
// ----------------------------------------------------------------------------
`default_nettype none
package nte_pkg;
	localparam int TABLE_DEPTH = 16;
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam logic [15:0] PURGE_INTERVAL_RST = 16'd1000;

	typedef enum logic [1:0] {
		FUNC_TICK   = 2'd0,
		FUNC_UPDATE = 2'd1,
		FUNC_QUERY  = 2'd2,
		FUNC_NONE   = 2'd3
	} func_t;

	typedef enum logic {
		REG_PURGE_INTERVAL = 1'b0,
		REG_REPORT_LOST    = 1'b1
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOK,
		ST_PURGE,
		ST_FINISH
	} state_t;

	// Control broadcast from the sequencer to every cell.
	typedef struct packed {
		logic        purge;
		logic        refresh;
		logic [31:0] now;
		logic [31:0] addr;
		logic [31:0] fresh;
	} cell_ctrl_t;

	typedef struct packed {
		logic        valid;
		logic        hit;
		logic        expired;
		logic [31:0] addr;
		logic [31:0] expiry;
	} cell_stat_t;

	function automatic logic time_before(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] d;
		d = a - b;
		return d[31];
	endfunction
endpackage
`default_nettype wire

/* rtl/nte_cell.sv */
// ----------------------------------------------------------------------------
// Neighbor table cell
// One table entry: compares its address, refreshes its expiry, and loads or
// clears itself under the sequencer's control.
// ----------------------------------------------------------------------------
`default_nettype none
module nte_cell (
	input  wire                     clk,
	input  wire                     arst_n,
	input  nte_pkg::cell_ctrl_t     ctrl,
	input  wire                     load,
	input  wire                     kill,
	input  wire  [63:0]             geohash_in,
	input  wire  [15:0]             heading_in,
	output nte_pkg::cell_stat_t     stat
);
	import nte_pkg::*;

	logic        valid_q;
	logic [31:0] addr_q;
	logic [31:0] expiry_q;
	logic [63:0] geohash_q;
	logic [15:0] heading_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (kill) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			addr_q    <= ctrl.addr;
			expiry_q  <= ctrl.fresh;
			geohash_q <= geohash_in;
			heading_q <= heading_in;
		end else if (ctrl.refresh && stat.hit && time_before(expiry_q, ctrl.fresh)) begin
			expiry_q <= ctrl.fresh;
		end
	end

	always_comb begin
		stat.valid   = valid_q;
		stat.hit     = valid_q && (addr_q == ctrl.addr);
		stat.expired = valid_q && time_before(expiry_q, ctrl.now);
		stat.addr    = addr_q;
		stat.expiry  = expiry_q;
	end

	// Stored location data is kept for a future read path.
	logic unused_ok;
	assign unused_ok = ^{geohash_q, heading_q, ctrl.purge};
endmodule
`default_nettype wire

/* rtl/nte_seq.sv */
// ----------------------------------------------------------------------------
// Neighbor table sequencer
// Holds time, the purge countdown and configuration; walks the cells during a
// purge and drives the result ports.
// ----------------------------------------------------------------------------
`default_nettype none
module nte_seq (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     start,
	output logic                    busy,
	input  wire  [1:0]              func,
	input  wire  [31:0]             neighbor_addr,
	input  wire  [15:0]             hold_time,
	input  wire                     cfg_valid,
	output logic                    cfg_ready,
	input  wire                     cfg_index,
	input  wire  [15:0]             cfg_data,
	input  nte_pkg::cell_stat_t     stat [nte_pkg::TABLE_DEPTH],
	output nte_pkg::cell_ctrl_t     ctrl,
	output logic [nte_pkg::TABLE_DEPTH-1:0] load,
	output logic [nte_pkg::TABLE_DEPTH-1:0] kill,
	output logic                    strobe,
	output logic                    kind,
	output logic [31:0]             lost_addr,
	output logic                    found,
	output logic [31:0]             time_left,
	output logic                    table_full,
	output logic                    last
);
	import nte_pkg::*;

	state_t      state_q, state_d;
	func_t       func_q;
	logic [31:0] addr_q, fresh_q, now_q;
	logic [15:0] countdown_q, interval_q;
	logic        report_q;
	logic [IDX_W-1:0] ptr_q;
	logic        ptr_end;
	logic [TABLE_DEPTH-1:0] hit_v, valid_v;
	logic        any_hit;
	logic [IDX_W-1:0] hit_idx, free_idx;
	logic        any_free;
	logic        cur_exp;

	always_comb begin
		hit_idx  = '0;
		free_idx = '0;
		any_free = 1'b0;
		for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
			hit_v[i]   = stat[i].hit;
			valid_v[i] = stat[i].valid;
			if (stat[i].hit) hit_idx = IDX_W'(i);
			if (!stat[i].valid) begin
				free_idx = IDX_W'(i);
				any_free = 1'b1;
			end
		end
		any_hit = |hit_v;
	end

	assign ptr_end = (ptr_q == IDX_W'(TABLE_DEPTH - 1));
	assign cur_exp = stat[ptr_q].expired;
	assign busy = (state_q != ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE) && !start;

	always_comb begin
		ctrl.purge   = (state_q == ST_PURGE);
		ctrl.refresh = (state_q == ST_LOOK) && (func_q == FUNC_UPDATE);
		ctrl.now     = now_q;
		ctrl.addr    = addr_q;
		ctrl.fresh   = fresh_q;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_LOOK;
			end
			ST_LOOK: begin
				case (func_q)
					FUNC_TICK:   state_d = (countdown_q <= 16'd1) ? ST_PURGE : ST_FINISH;
					FUNC_UPDATE: state_d = any_hit ? ST_FINISH : ST_PURGE;
					FUNC_QUERY:  state_d = ST_PURGE;
					default:     state_d = ST_FINISH;
				endcase
			end
			ST_PURGE: begin
				if (ptr_end) state_d = ST_FINISH;
			end
			ST_FINISH: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		load = '0;
		kill = '0;
		if (state_q == ST_PURGE && cur_exp) kill[ptr_q] = 1'b1;
		if (state_q == ST_FINISH && func_q == FUNC_UPDATE && !any_hit && any_free)
			load[free_idx] = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			now_q       <= '0;
			countdown_q <= PURGE_INTERVAL_RST;
			interval_q  <= PURGE_INTERVAL_RST;
			report_q    <= 1'b1;
			ptr_q       <= '0;
			strobe      <= 1'b0;
		end else begin
			state_q <= state_d;
			strobe  <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				case (reg_idx_t'(cfg_index))
					REG_PURGE_INTERVAL: interval_q <= cfg_data;
					REG_REPORT_LOST:    report_q   <= cfg_data[0];
					default: ;
				endcase
			end
			if (state_q == ST_IDLE && start && func_t'(func) == FUNC_TICK) begin
				now_q <= now_q + 32'd1;
			end
			if (state_q == ST_LOOK && func_q == FUNC_TICK && countdown_q > 16'd1) begin
				countdown_q <= countdown_q - 16'd1;
			end
			if (state_q == ST_LOOK) ptr_q <= '0;
			if (state_q == ST_PURGE) begin
				ptr_q <= ptr_q + IDX_W'(1);
				if (ptr_end) countdown_q <= interval_q;
				if (cur_exp && report_q) strobe <= 1'b1;
			end
			if (state_q == ST_FINISH) strobe <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			func_q  <= func_t'(func);
			addr_q  <= neighbor_addr;
			fresh_q <= now_q + 32'(hold_time) + ((func_t'(func) == FUNC_TICK) ? 32'd1 : 32'd0);
		end
		if (state_q == ST_PURGE) begin
			kind       <= 1'b0;
			lost_addr  <= stat[ptr_q].addr;
			found      <= 1'b0;
			time_left  <= '0;
			table_full <= 1'b0;
			last       <= 1'b0;
		end
		if (state_q == ST_FINISH) begin
			kind       <= 1'b1;
			lost_addr  <= '0;
			found      <= (func_q == FUNC_QUERY) && any_hit;
			time_left  <= ((func_q == FUNC_QUERY) && any_hit) ?
				(stat[hit_idx].expiry - now_q) : 32'd0;
			table_full <= (func_q == FUNC_UPDATE) && !any_hit && !any_free;
			last       <= 1'b1;
		end
	end

	logic unused_ok;
	assign unused_ok = ^valid_v;
endmodule
`default_nettype wire

/* rtl/neighbor_table_with_expiry_unit.sv */
// ----------------------------------------------------------------------------
// Neighbor table with expiry
// Sixteen entry neighbor table with aging, purge and link-lost reporting.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake            Payload
// item      in         start / busy         func, neighbor_addr, hold_time,
//                                           geohash, heading
// result    out        strobe, no stall     kind, lost_addr, found, time_left,
//                                           table_full, last
// config    in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Updates that hit and ticks that do not purge skip the cell walk and go from LOOK to FINISH.
// A purge steps one cell per cycle, visiting all TABLE_DEPTH cells in order.
// Each link-lost transfer leaves during the cell walk; the status transfer ends it.
// Reset clears all entries, time, and loads the default configuration.
// The receiver cannot stall; configuration is taken only while idle.
`default_nettype none
`include "neighbor_table_with_expiry_unit_defines.svh"
module neighbor_table_with_expiry_unit (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	output logic        busy,
	input  wire  [1:0]  func,
	input  wire  [31:0] neighbor_addr,
	input  wire  [15:0] hold_time,
	input  wire  [63:0] geohash,
	input  wire  [15:0] heading,
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire         cfg_index,
	input  wire  [15:0] cfg_data,
	output logic        strobe,
	output logic        kind,
	output logic [31:0] lost_addr,
	output logic        found,
	output logic [31:0] time_left,
	output logic        table_full,
	output logic        last
);
	import nte_pkg::*;

	cell_ctrl_t ctrl;
	cell_stat_t stat [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] load, kill;
	logic [63:0] geohash_q;
	logic [15:0] heading_q;

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			geohash_q <= geohash;
			heading_q <= heading;
		end
	end

	for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
		nte_cell u_cell (
			.clk(clk), .arst_n(arst_n), .ctrl(ctrl), .load(load[g]), .kill(kill[g]),
			.geohash_in(geohash_q), .heading_in(heading_q), .stat(stat[g])
		);
	end

	nte_seq u_seq (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .func(func),
		.neighbor_addr(neighbor_addr), .hold_time(hold_time),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .stat(stat), .ctrl(ctrl), .load(load), .kill(kill),
		.strobe(strobe), .kind(kind), .lost_addr(lost_addr), .found(found),
		.time_left(time_left), .table_full(table_full), .last(last)
	);

	`NTE_ASSERT(a_onehot_load, clk, arst_n, $onehot0(load), "more than one cell loaded")
	`NTE_ASSERT(a_cfg_idle, clk, arst_n, !(cfg_ready && busy), "config taken while busy")
	`NTE_ASSERT(a_last_ends, clk, arst_n, strobe && last |-> !busy, "busy during final status")
	`NTE_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy, "idle after accept")
endmodule
`default_nettype wire

/* tb/nte_scoreboard.sv */
// ----------------------------------------------------------------------------
// Neighbor table checker
// Watches the item, configuration and result channels of the neighbor table.
// It keeps its own copy of the table, time and purge countdown, predicts every
// result of each accepted item and compares the results in arrival order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module nte_scoreboard (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	input  wire         busy,
	input  wire  [1:0]  func,
	input  wire  [31:0] neighbor_addr,
	input  wire  [15:0] hold_time,
	input  wire  [63:0] geohash,
	input  wire  [15:0] heading,
	input  wire         cfg_valid,
	input  wire         cfg_ready,
	input  wire         cfg_index,
	input  wire  [15:0] cfg_data,
	input  wire         strobe,
	input  wire         kind,
	input  wire  [31:0] lost_addr,
	input  wire         found,
	input  wire  [31:0] time_left,
	input  wire         table_full,
	input  wire         last,
	output int          errors,
	output int          pending
);
	import nte_pkg::*;

	typedef struct {
		logic        kind;
		logic [31:0] lost_addr;
		logic        found;
		logic [31:0] time_left;
		logic        table_full;
		logic        last;
	} nbr_result_t;

	nbr_result_t due_results[$];

	logic [15:0] interval;
	logic        report_lost;
	logic        slot_used[TABLE_DEPTH];
	logic [31:0] slot_addr[TABLE_DEPTH];
	logic [31:0] slot_expiry[TABLE_DEPTH];
	logic [63:0] slot_geohash[TABLE_DEPTH];
	logic [15:0] slot_heading[TABLE_DEPTH];
	logic [31:0] now;
	logic [15:0] countdown;

	function automatic logic expires_before(logic [31:0] a, logic [31:0] b);
		logic [31:0] d;
		d = a - b;
		return d[31];
	endfunction

	function automatic void sweep_table();
		nbr_result_t r;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			if (slot_used[i] && expires_before(slot_expiry[i], now)) begin
				slot_used[i] = 1'b0;
				if (report_lost) begin
					r = '{1'b0, slot_addr[i], 1'b0, 32'd0, 1'b0, 1'b0};
					due_results.insert(due_results.size(), r);
				end
			end
		end
		countdown = interval;
	endfunction

	function automatic int lookup_slot(logic [31:0] a);
		for (int i = 0; i < TABLE_DEPTH; i++)
			if (slot_used[i] && slot_addr[i] == a)
				return i;
		return -1;
	endfunction

	function automatic void predict_item(func_t f, logic [31:0] a, logic [15:0] hold,
			logic [63:0] gh, logic [15:0] hd);
		nbr_result_t st;
		logic [31:0] fresh;
		int idx;
		st = '{1'b1, 32'd0, 1'b0, 32'd0, 1'b0, 1'b1};
		fresh = now + {16'd0, hold};
		case (f)
			FUNC_TICK: begin
				now = now + 32'd1;
				if (countdown <= 16'd1)
					sweep_table();
				else
					countdown = countdown - 16'd1;
			end
			FUNC_UPDATE: begin
				idx = lookup_slot(a);
				if (idx >= 0) begin
					if (expires_before(slot_expiry[idx], fresh))
						slot_expiry[idx] = fresh;
				end else begin
					sweep_table();
					for (int i = 0; i < TABLE_DEPTH; i++)
						if (!slot_used[i] && idx < 0)
							idx = i;
					if (idx >= 0) begin
						slot_used[idx] = 1'b1;
						slot_addr[idx] = a;
						slot_expiry[idx] = fresh;
						slot_geohash[idx] = gh;
						slot_heading[idx] = hd;
					end else begin
						st.table_full = 1'b1;
					end
				end
			end
			FUNC_QUERY: begin
				sweep_table();
				idx = lookup_slot(a);
				if (idx >= 0) begin
					st.found = 1'b1;
					st.time_left = slot_expiry[idx] - now;
				end
			end
			default: ;
		endcase
		due_results.insert(due_results.size(), st);
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("%0t mismatch in %s: got %0h, want %0h", $realtime, what, got, want);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		nbr_result_t w;
		if (!arst_n) begin
			interval = PURGE_INTERVAL_RST;
			report_lost = 1'b1;
			now = 32'd0;
			countdown = PURGE_INTERVAL_RST;
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				slot_used[i] = 1'b0;
				slot_addr[i] = 32'd0;
				slot_expiry[i] = 32'd0;
				slot_geohash[i] = 64'd0;
				slot_heading[i] = 16'd0;
			end
			due_results.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (strobe) begin
				if (due_results.size() == 0) begin
					report_mismatch("unexpected transfer, lost_addr", lost_addr, 32'd0);
				end else begin
					w = due_results.pop_front();
					if (kind !== w.kind)
						report_mismatch("kind", 32'(kind), 32'(w.kind));
					if (lost_addr !== w.lost_addr)
						report_mismatch("lost_addr", lost_addr, w.lost_addr);
					if (found !== w.found)
						report_mismatch("found", 32'(found), 32'(w.found));
					if (time_left !== w.time_left)
						report_mismatch("time_left", time_left, w.time_left);
					if (table_full !== w.table_full)
						report_mismatch("table_full", 32'(table_full), 32'(w.table_full));
					if (last !== w.last)
						report_mismatch("last", 32'(last), 32'(w.last));
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_PURGE_INTERVAL)
					interval = cfg_data;
				else
					report_lost = cfg_data[0];
			end
			if (start && !busy)
				predict_item(func_t'(func), neighbor_addr, hold_time, geohash, heading);
			pending = due_results.size();
		end
	end
endmodule
`default_nettype wire

/* tb/tb_neighbor_table_with_expiry_unit.sv */
// ----------------------------------------------------------------------------
// Neighbor table testbench
// Drives directed and random ticks, updates and queries into the neighbor
// table under several purge settings, with random gaps between transfers.
// The checker beside the block predicts and compares all results.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module tb_neighbor_table_with_expiry_unit;
	import nte_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [1:0]  func = 2'd0;
	logic [31:0] neighbor_addr = 32'd0;
	logic [15:0] hold_time = 16'd0;
	logic [63:0] geohash = 64'd0;
	logic [15:0] heading = 16'd0;
	logic        cfg_valid = 1'b0;
	logic        cfg_index = 1'b0;
	logic [15:0] cfg_data = 16'd0;
	wire         busy, cfg_ready, strobe, kind, found, table_full, last;
	wire  [31:0] lost_addr, time_left;
	int          errors, pending;
	int          item_count = 0;

	always #6 clk = ~clk;

	neighbor_table_with_expiry_unit uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .func(func),
		.neighbor_addr(neighbor_addr), .hold_time(hold_time), .geohash(geohash),
		.heading(heading), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data), .strobe(strobe), .kind(kind),
		.lost_addr(lost_addr), .found(found), .time_left(time_left),
		.table_full(table_full), .last(last)
	);

	nte_scoreboard checker_i (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .func(func),
		.neighbor_addr(neighbor_addr), .hold_time(hold_time), .geohash(geohash),
		.heading(heading), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data), .strobe(strobe), .kind(kind),
		.lost_addr(lost_addr), .found(found), .time_left(time_left),
		.table_full(table_full), .last(last), .errors(errors), .pending(pending)
	);

	task automatic send_item(func_t f, logic [31:0] a, logic [15:0] hold,
			logic [63:0] gh, logic [15:0] hd);
		start <= 1'b1;
		func <= f;
		neighbor_addr <= a;
		hold_time <= hold;
		geohash <= gh;
		heading <= hd;
		do @(negedge clk); while (busy);
		@(posedge clk);
		item_count++;
	endtask

	task automatic pause_sender(int cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	task automatic drain_results();
		start <= 1'b0;
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [15:0] val);
		drain_results();
		repeat (40) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [31:0] pick_addr();
		if ($urandom_range(0, 9) == 0)
			return $urandom;
		return {16'hc0a8, 11'd0, 5'($urandom_range(0, 23))};
	endfunction

	function automatic logic [15:0] pick_hold();
		if ($urandom_range(0, 19) == 0)
			return 16'($urandom);
		return 16'($urandom_range(0, 30));
	endfunction

	task automatic random_items(int n);
		int r;
		func_t f;
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(0, 99);
			f = r < 45 ? FUNC_TICK : r < 80 ? FUNC_UPDATE : r < 97 ? FUNC_QUERY : FUNC_NONE;
			send_item(f, pick_addr(), pick_hold(), {$urandom, $urandom}, 16'($urandom));
			if ((item_count < 220 || item_count > 320) && $urandom_range(0, 9) == 0)
				pause_sender($urandom_range(1, 6));
			if (k == n / 2 && n > 100)
				drain_results();
		end
	endtask

	initial begin
		#2ms;
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(FUNC_TICK, 32'd0, 16'd0, 64'd0, 16'd0);
		send_item(FUNC_UPDATE, 32'd0, 16'd0, '1, 16'hffff);
		send_item(FUNC_UPDATE, 32'hffffffff, 16'hffff, 64'd0, 16'd0);
		send_item(FUNC_UPDATE, 32'hffffffff, 16'd5, 64'd1, 16'd1);
		send_item(FUNC_QUERY, 32'hffffffff, 16'hffff, '1, 16'hffff);
		send_item(FUNC_QUERY, 32'h12345678, 16'd0, 64'd0, 16'd0);
		send_item(FUNC_NONE, 32'h5a5a5a5a, 16'h1234, '1, 16'h5555);
		for (int i = 1; i <= 15; i++)
			send_item(FUNC_UPDATE, 32'hc0a80100 + i, 16'd1, {$urandom, $urandom},
				16'($urandom));
		send_item(FUNC_TICK, 32'd0, 16'd0, 64'd0, 16'd0);
		send_item(FUNC_TICK, 32'd0, 16'd0, 64'd0, 16'd0);
		send_item(FUNC_QUERY, 32'd0, 16'd0, 64'd0, 16'd0);

		write_reg(REG_PURGE_INTERVAL, 16'd3);
		random_items(150);
		write_reg(REG_REPORT_LOST, 16'd0);
		write_reg(REG_PURGE_INTERVAL, 16'd1);
		random_items(90);
		write_reg(REG_REPORT_LOST, 16'd1);
		write_reg(REG_PURGE_INTERVAL, 16'hffff);
		random_items(80);
		write_reg(REG_PURGE_INTERVAL, 16'd0);
		random_items(80);
		write_reg(REG_PURGE_INTERVAL, 16'd7);
		random_items(60);

		drain_results();
		repeat (40) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule
`default_nettype wire

/* sim.f */
+incdir+rtl
rtl/nte_pkg.sv
rtl/nte_cell.sv
rtl/nte_seq.sv
rtl/neighbor_table_with_expiry_unit.sv
tb/nte_scoreboard.sv
tb/tb_neighbor_table_with_expiry_unit.sv
